// ===== rtl/core/mp_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 int8 max-pool unit.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package mp_pkg;

	localparam int CHANNELS  = 4;
	localparam int SAMP_W    = 8;
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int IW_W      = 11;
	localparam int OW_W      = 10;
	localparam int OH_W      = 16;
	localparam int ROW_W     = OH_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [IW_W-1:0] IN_WIDTH_RST   = 11'd3;
	localparam logic [OW_W-1:0] OUT_WIDTH_RST  = 10'd1;
	localparam logic [OH_W-1:0] OUT_HEIGHT_RST = 16'd1;

	// Smallest usable row width, and the largest the line store can hold.
	localparam logic [IW_W-1:0] IN_WIDTH_MIN = 11'd3;
	localparam logic [IW_W-1:0] IN_WIDTH_MAX = IW_W'(MAX_WIDTH);

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef samp_t [CHANNELS-1:0] pix_t;

	// One line store entry: the pixel one row up sits in the upper half.
	typedef struct packed {
		pix_t mid;
		pix_t top;
	} line_t;

	// Position information for the item at the head of the input channel.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             emit;
		logic             frame_end;
	} pos_t;

	// Per-channel signed maximum of two packed pixels.
	function automatic pix_t pmax(pix_t a, pix_t b);
		pix_t r;
		for (int k = 0; k < CHANNELS; k++) begin
			r[k] = ($signed(a[k]) > $signed(b[k])) ? a[k] : b[k];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mp_pix_if.sv =====
// Input pixel channel of the max-pool unit: valid/ready plus four int8 samples.
// Depends on mp_pkg.
`default_nettype none

interface mp_pix_if import mp_pkg::*;;
	logic  valid;
	logic  ready;
	samp_t chan0;
	samp_t chan1;
	samp_t chan2;
	samp_t chan3;

	modport source (output valid, output chan0, output chan1, output chan2, output chan3,
		input ready);
	modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mp_res_if.sv =====
// Result channel of the max-pool unit: valid/ready, four maxima and a frame marker.
// Depends on mp_pkg.
`default_nettype none

interface mp_res_if import mp_pkg::*;;
	logic  valid;
	logic  ready;
	samp_t max0;
	samp_t max1;
	samp_t max2;
	samp_t max3;
	logic  frame_end;

	modport source (output valid, output max0, output max1, output max2, output max3,
		output frame_end, input ready);
	modport sink (input valid, input max0, input max1, input max2, input max3,
		input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mp_cfg_if.sv =====
// Configuration write channel of the max-pool unit: valid/ready, index and data.
// Depends on mp_pkg.
`default_nettype none

interface mp_cfg_if import mp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mp_line_ram.sv =====
// Line store of the max-pool unit: one entry per column holding two rows.
// Single write port, single registered read port. Depends on mp_pkg.
`default_nettype none

module mp_line_ram import mp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	output line_t                 rd_data,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  line_t                 wr_data
);

	line_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mp_pos_ctrl.sv =====
// Configuration registers and raster position counters of the max-pool unit.
// Works out column, output gating and frame end for the next pixel. Depends on mp_pkg.
`default_nettype none

module mp_pos_ctrl import mp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mp_cfg_if.sink    cfg,
	input  wire logic acc,
	output pos_t      pos
);

	logic [IW_W-1:0]  in_width_q;
	logic [OW_W-1:0]  out_width_q;
	logic [OH_W-1:0]  out_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [IW_W-1:0]  iw;
	logic [IW_W-1:0]  iw_m2;
	logic [OW_W-1:0]  ow;
	logic [OH_W-1:0]  oh;
	logic [IW_W-1:0]  col_c;
	logic [COL_W-1:0] col;
	logic [OW_W-1:0]  col_m2;
	logic             last_col;
	logic             last_row;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= IN_WIDTH_RST;
			out_width_q  <= OUT_WIDTH_RST;
			out_height_q <= OUT_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IN_WIDTH:   in_width_q   <= cfg.data[IW_W-1:0];
				REG_OUT_WIDTH:  out_width_q  <= cfg.data[OW_W-1:0];
				REG_OUT_HEIGHT: out_height_q <= cfg.data[OH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective settings after clamping.
	always_comb begin
		iw = in_width_q;
		if (iw < IN_WIDTH_MIN) iw = IN_WIDTH_MIN;
		if (iw > IN_WIDTH_MAX) iw = IN_WIDTH_MAX;
		iw_m2 = iw - IW_W'(2);
		ow = out_width_q;
		if (ow == '0) ow = OW_W'(1);
		if ({1'b0, ow} > iw_m2) ow = iw_m2[OW_W-1:0];
		oh = (out_height_q == '0) ? OH_W'(1) : out_height_q;
	end

	// Position of the pixel at the head of the input channel.
	always_comb begin
		col_c = {1'b0, col_q};
		if (col_c >= iw) col_c = iw - IW_W'(1);
		col      = col_c[COL_W-1:0];
		col_m2   = col_c[OW_W-1:0] - OW_W'(2);
		last_col = (col_c == iw - IW_W'(1));
		last_row = (row_q >= {1'b0, oh} + ROW_W'(1));
		pos.col       = col;
		pos.emit      = (row_q >= ROW_W'(2)) && (col_c >= IW_W'(2)) && (col_m2 < ow);
		pos.frame_end = last_row && (col_m2 == ow - OW_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mp_window.sv =====
// Window datapath of the max-pool unit: vertical column maximum, the two
// column registers and the 3x3 maximum. Depends on mp_pkg.
`default_nettype none

module mp_window import mp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  line_t     rd_line,
	input  pix_t      cur,
	output line_t     wr_line,
	output pix_t      win_max
);

	pix_t vmax_prev1_q;
	pix_t vmax_prev2_q;
	pix_t vmax;

	assign vmax         = pmax(pmax(rd_line.top, rd_line.mid), cur);
	assign win_max      = pmax(pmax(vmax_prev2_q, vmax_prev1_q), vmax);
	assign wr_line.top  = rd_line.mid;
	assign wr_line.mid  = cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmax_prev1_q <= '0;
			vmax_prev2_q <= '0;
		end else if (adv) begin
			vmax_prev2_q <= vmax_prev1_q;
			vmax_prev1_q <= vmax;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/max_pool_3x3_s1_int8_x4_unit.sv =====
// 3x3 stride-1 max pooling on a padded int8 feature map with four packed
// channels per pixel. Pixels arrive in raster order on pix, one transfer per
// pixel, and the unit takes one pixel every clock cycle for as long as the
// result side keeps up. A frame is out_height+2 rows of in_width pixels;
// from the third row and third column onwards each pixel whose output column
// lies below out_width yields one transfer on res carrying the per-channel
// signed maximum of the 3x3 window that ends at it, with frame_end set on the
// last result of the frame. The cycle of the transfer reads the line store
// entry for the pixel's column and registers the pixel in stage one, which
// then forms the column and window maxima and loads the output register.
// The single-port read and write of the line store per pixel set the rate
// at one pixel per cycle while the result side keeps up. The output register
// parts the two sides: while a result waits there, pixels are still taken
// until stage one holds one that has a result of its own, which then waits
// for that transfer. Registers are written on cfg (0: in_width, 1: out_width,
// 2: out_height) and must only be changed while the unit is idle; in_width is
// clamped to 3..1024 and out_width to 1..in_width-2. The line store needs no
// clearing after reset: the first two rows of a frame write every entry that
// the results of that frame later read.
// Depends on mp_pkg, the channel interfaces, mp_pos_ctrl, mp_line_ram and mp_window.
`default_nettype none

module max_pool_3x3_s1_int8_x4_unit import mp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mp_pix_if.sink    pix,
	mp_res_if.source  res,
	mp_cfg_if.sink    cfg
);

	pos_t             pos;
	logic             acc;
	logic             s1_adv;
	logic             s1_valid;
	pix_t             s1_pix;
	logic [COL_W-1:0] s1_col;
	logic             s1_emit;
	logic             s1_fend;
	line_t            rd_line;
	line_t            wr_line;
	pix_t             win_max;
	pix_t             pix_in;
	logic             out_valid_q;
	pix_t             out_max_q;
	logic             out_fend_q;

	assign pix_in[0] = pix.chan0;
	assign pix_in[1] = pix.chan1;
	assign pix_in[2] = pix.chan2;
	assign pix_in[3] = pix.chan3;

	// Stage one moves on unless it holds a result and the output register is
	// still full with one that has not been transferred. A pixel with no
	// result never waits.
	assign s1_adv    = s1_valid && (!s1_emit || !out_valid_q || res.ready);
	assign pix.ready = !s1_valid || s1_adv;
	assign acc       = pix.valid && pix.ready;

	mp_pos_ctrl u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.acc    (acc),
		.pos    (pos)
	);

	// The entry is read on the transfer and written back as the pixel leaves
	// stage one. The same column comes round again only after at least two
	// other pixels, so a read never sees a stale entry.
	mp_line_ram u_ram (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (pos.col),
		.rd_data (rd_line),
		.wr_en   (s1_adv),
		.wr_addr (s1_col),
		.wr_data (wr_line)
	);

	mp_window u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (s1_adv),
		.rd_line (rd_line),
		.cur     (s1_pix),
		.wr_line (wr_line),
		.win_max (win_max)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pix.ready) begin
			s1_valid <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_pix  <= pix_in;
			s1_col  <= pos.col;
			s1_emit <= pos.emit;
			s1_fend <= pos.frame_end;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emit) begin
			out_max_q  <= win_max;
			out_fend_q <= s1_fend;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.max0      = out_max_q[0];
	assign res.max1      = out_max_q[1];
	assign res.max2      = out_max_q[2];
	assign res.max3      = out_max_q[3];
	assign res.frame_end = out_fend_q;

`ifndef SYNTHESIS
	// Stage one only holds a pixel back for a result the sink has not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |-> out_valid_q && !res.ready)
		else $error("stage one stalled without a pending result");

	// An accepted pixel always occupies stage one in the next cycle.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid)
		else $error("accepted pixel lost before stage one");

	// A new result only appears after a result-bearing pixel left stage one.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && s1_emit))
		else $error("result appeared without a source pixel");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_max_pool_3x3_s1_int8_x4_unit.sv =====
// Self-checking testbench for max_pool_3x3_s1_int8_x4_unit: streams padded int8 frames,
// predicts every 3x3 window maximum in step with each pixel transfer and checks each result.
// Depends on mp_pkg, the three channel interfaces and the unit itself.

module tb_max_pool_3x3_s1_int8_x4_unit import mp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Time allowed for the pipeline to settle once the last result has been taken, with
	// some margin for pixels without a result.
	localparam int SETTLE_CYCLES = 4;
	// Cycles allowed at the end for outstanding results to arrive.
	localparam int DRAIN_LIMIT = 5000;
	// Hard stop for the whole run, well beyond the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;

	// Register index that selects no register; a write to it must leave everything alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam samp_t SAMP_MIN = samp_t'(-128);
	localparam samp_t SAMP_MAX = samp_t'(127);

	// One expected result: the four channel maxima and the end-of-frame marker.
	typedef struct packed {
		pix_t maxes;
		logic frame_end;
	} window_t;

	logic clk;
	logic arst_n;

	mp_pix_if pix ();
	mp_res_if res ();
	mp_cfg_if cfg ();

	max_pool_3x3_s1_int8_x4_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	// Shadow of the configuration registers, as written (before any clamping).
	logic [IW_W-1:0] cfg_in_width;
	logic [OW_W-1:0] cfg_out_width;
	logic [OH_W-1:0] cfg_out_height;

	// Shadow of the window state: line store, the vertical maxima of the two previous
	// columns, and the position of the next pixel within the frame.
	line_t       line_mem [MAX_WIDTH];
	pix_t        vmax_prev1;
	pix_t        vmax_prev2;
	int unsigned col_pos;
	int unsigned row_pos;

	window_t expected_windows [$];

	int unsigned pixels_sent     = 0;
	int unsigned windows_checked = 0;
	int unsigned frames_seen     = 0;
	int unsigned reg_writes      = 0;
	int unsigned errors          = 0;
	int unsigned cycles          = 0;

	// Percentage of cycles in which the pixel source holds back, and in which the result
	// sink refuses a transfer.
	int unsigned pix_gap_pct   = 0;
	int unsigned res_stall_pct = 0;

	// 50 MHz clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Watchdog: a missing transfer anywhere shows up here rather than as a hang.
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("%0t ns: run stopped after %0d cycles, %0d results still awaited",
			$time, cycles, expected_windows.size());
		$display("tb: failure");
		$finish;
	end

	// Result sink: ready is chosen afresh at every falling edge.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= ($urandom_range(99) >= res_stall_pct);
		end
	end

	// Per-channel signed maximum of two pixels.
	function automatic pix_t chan_max(pix_t a, pix_t b);
		pix_t m;
		int   x;
		int   y;
		for (int k = 0; k < CHANNELS; k++) begin
			x = $signed(a[k]);
			y = $signed(b[k]);
			m[k] = (x >= y) ? a[k] : b[k];
		end
		return m;
	endfunction

	// Row width in use: the register value held within 3..MAX_WIDTH.
	function automatic int unsigned eff_in_width();
		int unsigned w;
		w = cfg_in_width;
		if (w < IN_WIDTH_MIN) w = IN_WIDTH_MIN;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_out_height();
		return (cfg_out_height == '0) ? 1 : cfg_out_height;
	endfunction

	// Random pixel, with the extremes of the sample range drawn more often than chance.
	function automatic pix_t rand_pixel();
		pix_t p;
		for (int k = 0; k < CHANNELS; k++) begin
			case ($urandom_range(7))
				0: p[k] = SAMP_MIN;
				1: p[k] = SAMP_MAX;
				default: p[k] = samp_t'($urandom);
			endcase
		end
		return p;
	endfunction

	// Advances the shadow window state by one accepted pixel and queues the result it
	// produces, if any.
	task automatic predict_window(input pix_t p);
		int unsigned iw;
		int unsigned ow;
		int unsigned oh;
		int unsigned c;
		int unsigned r;
		pix_t        top;
		pix_t        mid;
		pix_t        vmax;
		window_t     want;
		iw = eff_in_width();
		ow = (cfg_out_width == '0) ? 1 : cfg_out_width;
		if (ow > iw - 2) ow = iw - 2;
		oh = eff_out_height();
		// A width that shrank under the current column ends the row at the new last column.
		c = (col_pos >= iw) ? iw - 1 : col_pos;
		r = row_pos;

		top  = line_mem[c].top;
		mid  = line_mem[c].mid;
		vmax = chan_max(chan_max(top, mid), p);
		line_mem[c].top = mid;
		line_mem[c].mid = p;

		if (r >= 2 && c >= 2 && c - 2 < ow) begin
			want.maxes     = chan_max(chan_max(vmax_prev2, vmax_prev1), vmax);
			want.frame_end = (r >= oh + 1) && (c - 2 == ow - 1);
			expected_windows.push_back(want);
		end

		vmax_prev2 = vmax_prev1;
		vmax_prev1 = vmax;

		if (c >= iw - 1) begin
			col_pos = 0;
			row_pos = (r >= oh + 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Offers one pixel, with random idle cycles ahead of it, and holds it until the unit
	// takes the transfer. Valid is left high so back-to-back pixels follow without a gap.
	task automatic send_pixel(input pix_t p);
		@(negedge clk);
		while ($urandom_range(99) < pix_gap_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.chan0 <= p[0];
		pix.chan1 <= p[1];
		pix.chan2 <= p[2];
		pix.chan3 <= p[3];
		do @(posedge clk); while (!pix.ready);
		predict_window(p);
		pixels_sent++;
	endtask

	// Stops the pixel stream and waits until every expected result has been taken and the
	// pipeline has had time to finish any pixel that yields none.
	task automatic wait_until_idle();
		@(negedge clk);
		pix.valid <= 1'b0;
		while (expected_windows.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write; the unit is brought to rest first, as its registers require.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		wait_until_idle();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_IN_WIDTH:   cfg_in_width   = val[IW_W-1:0];
			REG_OUT_WIDTH:  cfg_out_width  = val[OW_W-1:0];
			REG_OUT_HEIGHT: cfg_out_height = val[OH_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Random pixels until the shadow position says the frame is complete.
	task automatic send_to_frame_end();
		do send_pixel(rand_pixel()); while (col_pos != 0 || row_pos != 0);
	endtask

	// Reset values, one 3x3 frame: one channel stuck at the minimum, one with the maximum
	// in the first corner, one with it in the last corner, and one with a lone peak in
	// the centre.
	task automatic test_reset_defaults();
		pix_t p;
		for (int i = 0; i < 9; i++) begin
			p[0] = SAMP_MIN;
			p[1] = (i == 0) ? SAMP_MAX : SAMP_MIN;
			p[2] = (i == 8) ? SAMP_MAX : samp_t'(-i);
			p[3] = (i == 4) ? samp_t'(-1) : SAMP_MIN;
			send_pixel(p);
		end
	endtask

	// Register values outside their usable range: widths and heights of zero, an output
	// width beyond the row, and a write to the unused index.
	task automatic test_clamped_sizes();
		write_reg(REG_IN_WIDTH, 16'd0);
		write_reg(REG_OUT_WIDTH, 16'd0);
		write_reg(REG_OUT_HEIGHT, 16'd0);
		send_to_frame_end();
		write_reg(REG_IN_WIDTH, 16'd5);
		write_reg(REG_OUT_WIDTH, 16'd1023);
		write_reg(REG_OUT_HEIGHT, 16'd2);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_to_frame_end();
	endtask

	// All-ones writes: the row width saturates at the line store size, so forty pixels
	// stay within the first row. The width is then cut to twelve, which ends that row,
	// and two full rows of twelve follow with the output width held at two less.
	task automatic test_widest_rows();
		write_reg(REG_IN_WIDTH, 16'hFFFF);
		write_reg(REG_OUT_WIDTH, 16'hFFFF);
		write_reg(REG_OUT_HEIGHT, 16'h0000);
		repeat (40) send_pixel(rand_pixel());
		write_reg(REG_IN_WIDTH, 16'd12);
		send_to_frame_end();
	endtask

	// Registers rewritten part-way through a frame. The position counters are kept: a
	// column past the new width ends the row, and a row past the new height ends the frame.
	task automatic test_mid_frame_writes();
		write_reg(REG_IN_WIDTH, 16'd8);
		write_reg(REG_OUT_WIDTH, 16'd6);
		write_reg(REG_OUT_HEIGHT, 16'hFFFF);
		repeat (22) send_pixel(rand_pixel());
		// The widest-row test ended with a whole frame twelve pixels wide, so widening to
		// twelve here only reads entries that hold defined data.
		write_reg(REG_IN_WIDTH, 16'd12);
		repeat (5) send_pixel(rand_pixel());
		write_reg(REG_IN_WIDTH, 16'd4);
		send_pixel(rand_pixel());
		write_reg(REG_OUT_HEIGHT, 16'd1);
		send_to_frame_end();
	endtask

	// Whole frames of random size and content. Now and then a register is changed inside
	// a frame; the width never grows there, so no unwritten entry is read.
	task automatic test_random_frames(input int unsigned gap_pct, input int unsigned stall_pct,
		input int unsigned n_pixels);
		int unsigned first;
		int unsigned iw;
		int unsigned len;
		pix_gap_pct   = gap_pct;
		res_stall_pct = stall_pct;
		first = pixels_sent;
		while (pixels_sent - first < n_pixels) begin
			iw = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			if ($urandom_range(9) == 0)
				write_reg(REG_IN_WIDTH, CFG_DAT_W'($urandom_range(0, 2)));
			else
				write_reg(REG_IN_WIDTH, CFG_DAT_W'(iw));
			if ($urandom_range(1))
				write_reg(REG_OUT_WIDTH, CFG_DAT_W'($urandom_range(0, eff_in_width())));
			if ($urandom_range(1))
				write_reg(REG_OUT_HEIGHT, CFG_DAT_W'($urandom_range(0, 3)));
			if ($urandom_range(4) == 0) begin
				len = (eff_out_height() + 2) * eff_in_width();
				repeat ($urandom_range(1, len - 1)) send_pixel(rand_pixel());
				case ($urandom_range(2))
					0: write_reg(REG_IN_WIDTH, CFG_DAT_W'($urandom_range(0, eff_in_width())));
					1: write_reg(REG_OUT_WIDTH,
						CFG_DAT_W'($urandom_range(0, eff_in_width())));
					default: write_reg(REG_OUT_HEIGHT, CFG_DAT_W'($urandom_range(0, 3)));
				endcase
			end
			send_to_frame_end();
		end
	endtask

	// Every result transfer is compared with the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		window_t want;
		pix_t    got;
		if (arst_n && res.valid && res.ready) begin
			got[0] = res.max0;
			got[1] = res.max1;
			got[2] = res.max2;
			got[3] = res.max3;
			if (expected_windows.size() == 0) begin
				$display("%0t ns: result transfer with none expected (max %0d %0d %0d %0d)",
					$time, $signed(got[0]), $signed(got[1]), $signed(got[2]),
					$signed(got[3]));
				errors++;
			end else begin
				want = expected_windows.pop_front();
				for (int k = 0; k < CHANNELS; k++) begin
					if (got[k] !== want.maxes[k]) begin
						$display("%0t ns: max%0d expected %0d, got %0d", $time, k,
							$signed(want.maxes[k]), $signed(got[k]));
						errors++;
					end
				end
				if (res.frame_end !== want.frame_end) begin
					$display("%0t ns: frame_end expected %0b, got %0b", $time,
						want.frame_end, res.frame_end);
					errors++;
				end
				windows_checked++;
				if (want.frame_end) frames_seen++;
			end
		end
	end

	initial begin
		pix.valid = 1'b0;
		pix.chan0 = '0;
		pix.chan1 = '0;
		pix.chan2 = '0;
		pix.chan3 = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_IN_WIDTH;
		cfg.data  = '0;
		arst_n    = 1'b0;

		// The shadow state starts where the unit does after reset.
		cfg_in_width   = IN_WIDTH_RST;
		cfg_out_width  = OUT_WIDTH_RST;
		cfg_out_height = OUT_HEIGHT_RST;
		for (int i = 0; i < MAX_WIDTH; i++) line_mem[i] = '0;
		vmax_prev1 = '0;
		vmax_prev2 = '0;
		col_pos    = 0;
		row_pos    = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed tests run with both sides always ready.
		test_reset_defaults();
		test_clamped_sizes();
		test_widest_rows();
		test_mid_frame_writes();

		// Random frames under each mix of source gaps and sink stalls.
		test_random_frames(0, 0, 180);
		test_random_frames(71, 0, 180);
		test_random_frames(0, 71, 180);
		test_random_frames(20, 20, 180);

		@(negedge clk);
		pix.valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && expected_windows.size() != 0; n++) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_windows.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time,
				expected_windows.size());
			errors += expected_windows.size();
		end

		$display("Streamed %0d pixels, checked %0d window maxima over %0d frames,",
			pixels_sent, windows_checked, frames_seen);
		$display("with %0d register writes and four source/sink idling mixes; %0d errors.",
			reg_writes, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
